[src/swm_pkg.sv]
// shared types and constants for the sliding window maximum block
// no dependencies; imported by every module of the block
`default_nettype none

package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int WSIZE_W  = 7;

   localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd1;

   // one deque entry as held by a cell
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] value;
   } swm_entry_type;

endpackage

`default_nettype wire

[src/sliding_window_maximum.sv]
// sliding window maximum: top level with the cell row, sample count and result register
// depends on swm_pkg, swm_cell and swm_front
`default_nettype none

// Gives, for each signed request sample, the largest of the last window_size samples
// of the current sequence. The deque is a row of WINDOW_MAX cells in which cell i
// holds the sample taken i requests ago together with a keep bit; every accepted
// request shifts the row by one cell and, in parallel in every cell, drops the keep
// bit of entries that have aged out of the window or are not larger than the new
// sample. Kept entries therefore fall in value from the old end to the young end, and
// the window maximum is the oldest kept entry. One request is taken every clock unless
// req_stall is high; the edge that takes a request shifts the row and marks a result
// owed, which the rsp register loads once it is free, the front pick (priority one-hot
// and and-or select over the row) settling in between. req_stall rises only while a
// result is owed and the rsp register still holds an untaken one that is stalled.
// A request with req_first set clears the row and the sample count first; reset
// starts a sequence as well. window_size of zero gives no results and values above
// WINDOW_MAX act as WINDOW_MAX. csr writes belong to idle periods.
module sliding_window_maximum
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX = 64
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_first,
   // result channel
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic signed [SAMPLE_W-1:0] rsp_window_max,
   // window size register
   input  wire logic                       csr_wr_en,
   input  wire logic [WSIZE_W-1:0]         csr_wr_data
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

   // window size register
   logic [WSIZE_W-1:0] wsize_ff;
   logic [CMP_W-1:0]   wsize_eff;

   // sample count since sequence start, saturating at the window maximum
   logic [CNT_W-1:0] seen_ff;
   logic [CNT_W-1:0] seen_in;

   // result owed for an accepted request, held until the output register takes it
   logic pend_ff;
   logic pend_in;

   // output register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_max_ff;

   logic req_accept;
   logic capture;
   logic emit;

   swm_entry_type              cell_in   [WINDOW_MAX];
   swm_entry_type              cell_held [WINDOW_MAX];
   swm_entry_type              cell_pass [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]      expired;
   logic signed [SAMPLE_W-1:0] front_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff <= WSIZE_RESET;
      end else if (csr_wr_en) begin
         wsize_ff <= csr_wr_data;
      end
   end

   // sizes above the row length saturate
   assign wsize_eff = (CMP_W'(wsize_ff) > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX)
                                                              : CMP_W'(wsize_ff);

   // handshake: hold requests only while an owed result cannot move on
   assign capture    = pend_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = pend_ff & rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // sample count after this request
   always_comb begin
      if (req_first) begin
         seen_in = CNT_W'(1);
      end else if (seen_ff == CNT_W'(WINDOW_MAX)) begin
         seen_in = seen_ff;
      end else begin
         seen_in = seen_ff + CNT_W'(1);
      end
   end

   assign emit = (wsize_eff != '0) & (CMP_W'(seen_in) >= wsize_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (req_accept) begin
         seen_ff <= seen_in;
      end
   end

   always_comb begin
      if (req_accept) begin
         pend_in = emit;
      end else if (capture) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // cell row: the new sample enters at cell 0, survivors move one cell older
   assign cell_in[0].valid = 1'b1;
   assign cell_in[0].value = req_sample;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      // entry of cell i is i+1 samples old when the next sample arrives
      assign expired[i] = (CMP_W'(i + 1) >= wsize_eff);

      if (i > 0) begin : g_link
         assign cell_in[i] = cell_pass[i-1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (req_accept),
         .first      (req_first),
         .sample     (req_sample),
         .expired    (expired[i]),
         .entry_in   (cell_in[i]),
         .entry_held (cell_held[i]),
         .entry_pass (cell_pass[i])
      );
   end

   // front pick from the row as left by the last request
   swm_front #(
      .DEPTH (WINDOW_MAX)
   ) u_front (
      .entries     (cell_held),
      .front_value (front_value)
   );

   // output register
   always_comb begin
      if (capture) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_max_ff <= front_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

   // an accepted request always sits in the youngest cell afterwards
   a_youngest_cell : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (cell_held[0].valid && (cell_held[0].value == $past(req_sample))))
      else $error("request sample not held in the youngest cell");

   // an owed result always has a non-empty deque to pick from
   a_front_present : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (cell_held[0].valid))
      else $error("result owed with an empty deque");

   // an owed result blocked by the output register is not dropped
   a_result_kept : assert property (@(posedge clock) disable iff (reset)
      (pend_ff && rsp_valid_ff && rsp_stall) |=> pend_ff)
      else $error("owed result lost while the output was stalled");

endmodule

`default_nettype wire

[src/swm_cell.sv]
// one cell of the deque row: holds the entry of one sample age
// depends on swm_pkg
`default_nettype none

module swm_cell
   import swm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       shift_en,
   input  wire logic                       first,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic                       expired,
   input  wire swm_entry_type              entry_in,
   output      swm_entry_type              entry_held,
   output      swm_entry_type              entry_pass
);

   logic                       valid_ff;
   logic signed [SAMPLE_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= entry_in.value;
      end
   end

   assign entry_held.valid = valid_ff;
   assign entry_held.value = value_ff;

   // survives only if still in the window, larger than the new sample and no new sequence starts
   assign entry_pass.value = value_ff;
   assign entry_pass.valid = valid_ff & ~expired & ~first & (value_ff > sample);

endmodule

`default_nettype wire

[src/swm_front.sv]
// picks the front of the deque: the oldest valid cell of the row
// depends on swm_pkg
`default_nettype none

module swm_front
   import swm_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  wire swm_entry_type              entries [DEPTH],
   output      logic signed [SAMPLE_W-1:0] front_value
);

   logic [DEPTH-1:0] valid_vec;
   logic [DEPTH-1:0] pick;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         valid_vec[i] = entries[i].valid;
      end
   end

   // one-hot of the highest valid index
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         pick[i] = valid_vec[i] & ~(|(valid_vec >> (i + 1)));
      end
   end

   // and-or select, one reduction per bit
   always_comb begin
      logic [DEPTH-1:0] column;
      column = '0;
      for (int b = 0; b < SAMPLE_W; b++) begin
         for (int i = 0; i < DEPTH; i++) begin
            column[i] = entries[i].value[b] & pick[i];
         end
         front_value[b] = |column;
      end
   end

endmodule

`default_nettype wire

[sim/tb.sv]
// testbench for sliding_window_maximum: directed and random request streams
// checked against an in-bench deque predictor; depends on swm_pkg and the rtl top level
`default_nettype none

module tb
   import swm_pkg::*;
();

   // deque capacity and the modulus of the position counter
   localparam int WIN_CAP  = 64;
   localparam int POS_WRAP = 2 * WIN_CAP;
   // depth of the ring of owed results, well above what the block can hold
   localparam int OWED_DEPTH = 16;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_first;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_window_max;
   logic                       csr_wr_en;
   logic [WSIZE_W-1:0]         csr_wr_data;

   sliding_window_maximum #(
      .WINDOW_MAX(WIN_CAP)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_window_max (rsp_window_max),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state: our own copy of the deque, counters and window register
   logic signed [SAMPLE_W-1:0] dq_val [WIN_CAP];
   int                         dq_pos [WIN_CAP];
   int                         dq_cnt;
   int                         pos_ctr;
   int                         seen_cnt;
   logic [WSIZE_W-1:0]         win_size;

   // window maxima owed by the block, oldest first, kept in a ring
   logic signed [SAMPLE_W-1:0] owed_max [OWED_DEPTH];
   int                         owed_wr;
   int                         owed_rd;
   logic signed [SAMPLE_W-1:0] got_want;
   int                         mismatch_count;
   logic                       steady;     // suppresses all idling on both sides
   int                         trend_base; // running value for falling runs of samples

   // deque update for one accepted request; queues the front value when a result is owed
   task automatic track_window_max(input logic signed [SAMPLE_W-1:0] s, input logic first);
      int w;
      int pos;
      int age;
      int k;
      w = (win_size > WIN_CAP) ? WIN_CAP : int'(win_size);
      if (first) begin
         dq_cnt   = 0;
         pos_ctr  = 0;
         seen_cnt = 0;
      end
      pos = pos_ctr;
      // front: entries out of the window or not above the new sample
      while (dq_cnt > 0) begin
         age = (pos + POS_WRAP - dq_pos[0]) % POS_WRAP;
         if (age >= w || dq_val[0] <= s) begin
            for (k = 0; k < dq_cnt - 1; k++) begin
               dq_val[k] = dq_val[k+1];
               dq_pos[k] = dq_pos[k+1];
            end
            dq_cnt--;
         end else begin
            break;
         end
      end
      // back: entries out of the window or dominated by the new sample
      while (dq_cnt > 0) begin
         age = (pos + POS_WRAP - dq_pos[dq_cnt-1]) % POS_WRAP;
         if (age >= w || dq_val[dq_cnt-1] <= s)
            dq_cnt--;
         else
            break;
      end
      // full deque loses its oldest entry
      if (dq_cnt >= WIN_CAP) begin
         for (k = 0; k < WIN_CAP - 1; k++) begin
            dq_val[k] = dq_val[k+1];
            dq_pos[k] = dq_pos[k+1];
         end
         dq_cnt = WIN_CAP - 1;
      end
      dq_val[dq_cnt] = s;
      dq_pos[dq_cnt] = pos;
      dq_cnt++;
      pos_ctr = (pos + 1) % POS_WRAP;
      if (seen_cnt < WIN_CAP)
         seen_cnt++;
      if (w != 0 && seen_cnt >= w) begin
         owed_max[owed_wr % OWED_DEPTH] = dq_val[0];
         owed_wr++;
      end
   endtask

   // one request: random idle gaps first, then hold until taken at a rising edge
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic first);
      while (!steady && $urandom_range(99) < 16) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = s;
      req_first  = first;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      track_window_max(s, first);
      @(negedge clock);
   endtask

   // stop requesting and let every owed result arrive, then stay idle before returning
   task automatic wait_drained();
      int n;
      req_valid = 1'b0;
      n = 0;
      while (owed_wr != owed_rd && n < 5000) begin
         @(negedge clock);
         n++;
      end
      if (owed_wr != owed_rd) begin
         $error("window_max: %0d results never arrived", owed_wr - owed_rd);
         mismatch_count += owed_wr - owed_rd;
         owed_rd = owed_wr;
      end
      repeat (8) @(negedge clock);
   endtask

   // register write, only with the block idle
   task automatic set_window(input logic [WSIZE_W-1:0] v);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(posedge clock);
      win_size = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // mix of full-range values, a narrow band full of ties, extremes and falling runs
   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(16)) - 8;
         2: begin
            case ($urandom_range(2))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               default: return 0;
            endcase
         end
         default: begin
            trend_base = trend_base - int'($urandom_range(40));
            return trend_base;
         end
      endcase
   endfunction

   // reset opens a sequence by itself, window 1 echoes every sample
   task automatic test_reset_sequence();
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh7fff_ffff, 1'b0);
      send_sample(-1, 1'b0);
      send_sample(0, 1'b0);
   endtask

   // ties must displace older equal entries; window shrinks mid-sequence
   task automatic test_ties_and_shrink();
      set_window(7'd3);
      send_sample(5, 1'b1);
      send_sample(5, 1'b0);
      send_sample(-3, 1'b0);
      send_sample(-3, 1'b0);
      send_sample(-7, 1'b0);
      set_window(7'd2);
      send_sample(1, 1'b0);
      send_sample(-2, 1'b0);
      send_sample(-2, 1'b0);
   endtask

   // zero window: deque keeps moving but nothing comes out until the window is set back to 1
   task automatic test_zero_window();
      set_window(7'd0);
      send_sample(7, 1'b1);
      send_sample(8, 1'b0);
      send_sample(9, 1'b0);
      set_window(7'd1);
      send_sample(4, 1'b0);
   endtask

   // window above the deque size saturates; too few samples yet for a result
   task automatic test_oversize_window();
      set_window(7'd127);
      send_sample(32'sh7fff_ffff, 1'b1);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(3, 1'b0);
      send_sample(-3, 1'b0);
      send_sample(0, 1'b0);
   endtask

   // phases over several window sizes, mostly whole sequences with random content
   task automatic test_random_windows();
      logic [WSIZE_W-1:0] sizes [10];
      int   budget;
      int   len;
      int   weff;
      logic open_new;
      sizes = '{7'd1, 7'd2, 7'd5, 7'd17, 7'd63, 7'd64, 7'd0, 7'd127, 7'd65, 7'd0};
      sizes[9] = WSIZE_W'($urandom_range(127));
      for (int p = 0; p < 10; p++) begin
         set_window(sizes[p]);
         weff = (sizes[p] > WIN_CAP) ? WIN_CAP : int'(sizes[p]);
         // sometimes carry the old sequence on under the new window
         open_new = ($urandom_range(1) == 1);
         steady = (p == 5);
         budget = 120;
         while (budget > 0) begin
            // occasional long runs carry the position counter through its wrap
            len = ($urandom_range(9) == 0) ? $urandom_range(130, 200)
                                           : $urandom_range(1, 2 * weff + 8);
            for (int i = 0; i < len && budget > 0; i++) begin
               send_sample(rand_sample(), (i == 0 && open_new) || $urandom_range(199) == 0);
               budget--;
               // sender holds off once until the block has caught up
               if (p == 3 && budget == 60)
                  wait_drained();
            end
            open_new = 1'b1;
         end
      end
      steady = 1'b0;
   endtask

   // result side: random stalls at the falling edge
   always @(negedge clock)
      rsp_stall <= steady ? 1'b0 : ($urandom_range(99) < 16);

   // result check at the rising edge against the oldest owed maximum
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_wr == owed_rd) begin
            $error("window_max: none expected, got %0d", rsp_window_max);
            mismatch_count++;
         end else begin
            got_want = owed_max[owed_rd % OWED_DEPTH];
            owed_rd++;
            if (rsp_window_max !== got_want) begin
               $error("window_max: expected %0d, got %0d", got_want, rsp_window_max);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample     = '0;
      req_first      = 1'b0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      steady         = 1'b0;
      mismatch_count = 0;
      trend_base     = 0;
      dq_cnt         = 0;
      pos_ctr        = 0;
      seen_cnt       = 0;
      owed_wr        = 0;
      owed_rd        = 0;
      win_size       = WSIZE_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_sequence();
      test_ties_and_shrink();
      test_zero_window();
      test_oversize_window();
      test_random_windows();

      wait_drained();
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
src/swm_pkg.sv
src/swm_cell.sv
src/swm_front.sv
src/sliding_window_maximum.sv
sim/tb.sv
